/* sv/battery_monitor_display_top_assert.svh */
// Assertion macros used by the battery monitor display top level.
`ifndef BATTERY_MONITOR_DISPLAY_TOP_ASSERT_SVH
`define BATTERY_MONITOR_DISPLAY_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/bmd_pkg.sv */
// Shared types and constants of the battery monitor display block.
`default_nettype none

package bmd_pkg;

  // Field widths.
  localparam int ADC_W    = 12;
  localparam int REMOTE_W = 16;
  localparam int LOCAL_W  = 9;
  localparam int DIGIT_W  = 4;
  localparam int PERIOD_W = 8;
  localparam int BCD_N    = 5;
  localparam int STEP_W   = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Default ring depth.
  localparam int FILTER_DEPTH_DEF = 16;

  // Fixed-point scaling: a reading a gives a*4488/40950 (+1/2 for rounding).
  localparam logic [12:0] SCALE_NUM = 13'd4488;
  localparam logic [15:0] SCALE_DEN = 16'd40950;

  // Display and flicker codes.
  localparam logic [DIGIT_W-1:0]  BLANK_DIGIT = 4'd10;
  localparam logic [PERIOD_W-1:0] FLICK_LOW   = 8'd200;
  localparam logic [PERIOD_W-1:0] FLICK_OFF   = 8'd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PRODUCT_KIND = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLY_LIMIT    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAR_LIMIT    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_LIMIT  = 8'd3;

  // Configuration reset values.
  localparam logic [REMOTE_W-1:0] FLY_LIMIT_RST   = 16'd370;
  localparam logic [REMOTE_W-1:0] CAR_LIMIT_RST   = 16'd1100;
  localparam logic [LOCAL_W-1:0]  LOCAL_LIMIT_RST = 9'd360;

  // Configuration register set.
  typedef struct packed {
    logic                product_kind;
    logic [REMOTE_W-1:0] fly_limit;
    logic [REMOTE_W-1:0] car_limit;
    logic [LOCAL_W-1:0]  local_limit;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic acc;
    logic mul;
    logic add;
    logic div_step;
    logic conv_load;
    logic conv_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* sv/bmd_ctrl.sv */
// Sequencing controller of the battery monitor display block.
`default_nettype none

module bmd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire bmd_pkg::status_t st,
  output bmd_pkg::cmd_t        cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_SEL  = 3'd5;
  localparam logic [2:0] S_CONV = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  localparam logic [bmd_pkg::STEP_W-1:0] DIV_LAST  =
    bmd_pkg::STEP_W'(bmd_pkg::LOCAL_W - 1);
  localparam logic [bmd_pkg::STEP_W-1:0] CONV_LAST =
    bmd_pkg::STEP_W'(bmd_pkg::REMOTE_W - 1);

  logic [2:0]                   state_r, state_nxt;
  logic [bmd_pkg::STEP_W-1:0]   step_r, step_nxt;

  // Input is taken only when idle and out of reset.
  assign in_tready = rst_n && (state_r == S_IDLE);

  // Next state, step counter and commands.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.load  = 1'b1;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        cmd.conv_load = 1'b1;
        step_nxt      = '0;
        state_nxt     = S_CONV;
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == CONV_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/bmd_datapath.sv */
// Datapath: sample ring, averaging divider, decimal conversion and result register.
`default_nettype none

module bmd_datapath #(
  parameter int FILTER_DEPTH = bmd_pkg::FILTER_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bmd_pkg::cmd_t                 cmd,
  output bmd_pkg::status_t                   st,
  input  wire bmd_pkg::cfg_t                 cfg,
  input  wire logic [bmd_pkg::ADC_W-1:0]     in_adc,
  input  wire logic [bmd_pkg::REMOTE_W-1:0]  in_remote,
  input  wire logic                          in_tick,
  input  wire logic                          out_tready,
  output logic                               out_tvalid,
  output logic [31:0]                        out_tdata,
  output logic [1:0]                         out_tuser
);

  localparam int SLOT_W  = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int N_W     = $clog2(FILTER_DEPTH + 1);
  localparam int TOTAL_W = bmd_pkg::ADC_W + SLOT_W;
  localparam int PROD_W  = TOTAL_W + 13;
  localparam int DEN_W   = N_W + 16;
  localparam int NUM_W   = ((PROD_W > DEN_W) ? PROD_W : DEN_W) + 1;
  localparam int DIV_W   = (NUM_W > DEN_W + bmd_pkg::LOCAL_W) ? NUM_W
                                                              : DEN_W + bmd_pkg::LOCAL_W;
  localparam int BCD_W   = bmd_pkg::BCD_N * bmd_pkg::DIGIT_W;
  localparam int LW      = bmd_pkg::LOCAL_W;
  localparam int RW      = bmd_pkg::REMOTE_W;
  localparam int DW      = bmd_pkg::DIGIT_W;

  // Latched input item.
  logic [bmd_pkg::ADC_W-1:0] adc_r;
  logic [RW-1:0]             remote_r;
  logic                      tick_r;

  // Ring buffer and running total.
  logic [bmd_pkg::ADC_W-1:0] ring_mem [FILTER_DEPTH];
  logic [bmd_pkg::ADC_W-1:0] ring_rd_r;
  logic [SLOT_W-1:0]         slot_r, slot_nxt;
  logic                      full_r, full_nxt;
  logic [TOTAL_W-1:0]        total_r, total_nxt;
  logic [bmd_pkg::ADC_W-1:0] old_sample;
  logic [N_W-1:0]            count_n;
  logic                      show_local_r;

  // Scaling and division.
  logic [PROD_W-1:0] prod_r;
  logic [DEN_W-1:0]  den_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dsr_r;
  logic [LW-1:0]     quo_r;
  logic              quo_bit;

  // Decimal conversion.
  logic [RW-1:0]    bin_r;
  logic [BCD_W-1:0] bcd_r;
  logic [BCD_W-1:0] bcd_adj;
  logic [DW-1:0]    dig [bmd_pkg::BCD_N];
  logic [DW-1:0]    d_hi, d_mid, d_lo;

  // Result register.
  logic                      out_valid_r;
  logic [31:0]               out_tdata_r;
  logic [1:0]                out_tuser_r;
  logic [RW-1:0]             remote_limit;
  logic                      local_low, remote_low, shown_low;
  logic [bmd_pkg::PERIOD_W-1:0] period;

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      adc_r    <= in_adc;
      remote_r <= in_remote;
      tick_r   <= in_tick;
    end
  end

  // Ring memory: one write port, registered read at the current slot.
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      ring_mem[slot_r] <= adc_r;
    end
    ring_rd_r <= ring_mem[slot_r];
  end

  // Slots not yet written since reset are read as zero; they are exactly those past the fill point.
  assign old_sample = full_r ? ring_rd_r : '0;

  // Running total and slot pointer update.
  always_comb begin
    total_nxt = total_r - TOTAL_W'(old_sample) + TOTAL_W'(adc_r);
    full_nxt  = full_r;
    if (slot_r == SLOT_W'(FILTER_DEPTH - 1)) begin
      slot_nxt = '0;
      full_nxt = 1'b1;
    end else begin
      slot_nxt = slot_r + 1'b1;
    end
  end

  // Number of samples held, taken after the pointer update.
  assign count_n = full_r ? N_W'(FILTER_DEPTH) : N_W'(slot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r       <= '0;
      full_r       <= 1'b0;
      total_r      <= '0;
      show_local_r <= 1'b0;
    end else begin
      if (cmd.acc) begin
        slot_r  <= slot_nxt;
        full_r  <= full_nxt;
        total_r <= total_nxt;
      end
      if (cmd.add && tick_r) begin
        show_local_r <= ~show_local_r;
      end
    end
  end

  // Scaled total and divisor, one multiplier on each path.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(total_r) * PROD_W'(bmd_pkg::SCALE_NUM);
      den_r  <= DEN_W'(count_n) * DEN_W'(bmd_pkg::SCALE_DEN);
    end
  end

  // Restoring division, one quotient bit a cycle, most significant first.
  assign quo_bit = (rem_r >= dsr_r);

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      rem_r <= DIV_W'(prod_r) + DIV_W'(den_r >> 1);
      dsr_r <= DIV_W'(den_r) << (LW - 1);
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (quo_bit) begin
        rem_r <= rem_r - dsr_r;
      end
      dsr_r <= dsr_r >> 1;
      quo_r <= {quo_r[LW-2:0], quo_bit};
    end
  end

  // Shift-and-add-3 correction of every BCD digit.
  always_comb begin
    for (int i = 0; i < bmd_pkg::BCD_N; i++) begin
      if (bcd_r[i*DW +: DW] >= 4'd5) begin
        bcd_adj[i*DW +: DW] = bcd_r[i*DW +: DW] + 4'd3;
      end else begin
        bcd_adj[i*DW +: DW] = bcd_r[i*DW +: DW];
      end
    end
  end

  // Binary to BCD conversion, one bit a cycle.
  always_ff @(posedge clk) begin
    if (cmd.conv_load) begin
      bin_r <= show_local_r ? RW'(quo_r) : remote_r;
      bcd_r <= '0;
    end else if (cmd.conv_step) begin
      bcd_r <= {bcd_adj[BCD_W-2:0], bin_r[RW-1]};
      bin_r <= {bin_r[RW-2:0], 1'b0};
    end
  end

  // Leading three digits of the decimal string.
  always_comb begin
    for (int i = 0; i < bmd_pkg::BCD_N; i++) begin
      dig[i] = bcd_r[i*DW +: DW];
    end
    if (dig[4] != '0) begin
      d_hi = dig[4]; d_mid = dig[3]; d_lo = dig[2];
    end else if (dig[3] != '0) begin
      d_hi = dig[3]; d_mid = dig[2]; d_lo = dig[1];
    end else if (dig[2] != '0) begin
      d_hi = dig[2]; d_mid = dig[1]; d_lo = dig[0];
    end else if (dig[1] != '0) begin
      d_hi = dig[1]; d_mid = dig[0]; d_lo = bmd_pkg::BLANK_DIGIT;
    end else begin
      d_hi = dig[0]; d_mid = bmd_pkg::BLANK_DIGIT; d_lo = bmd_pkg::BLANK_DIGIT;
    end
  end

  // Threshold checks and flicker period.
  assign remote_limit = cfg.product_kind ? cfg.car_limit : cfg.fly_limit;
  assign local_low    = (quo_r < cfg.local_limit);
  assign remote_low   = (remote_r < remote_limit);
  assign shown_low    = show_local_r ? local_low : remote_low;
  assign period       = (tick_r && shown_low) ? bmd_pkg::FLICK_LOW : bmd_pkg::FLICK_OFF;

  // The result register may be refilled once its transaction completes.
  assign st.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata_r <= {2'b00, (local_low || remote_low), period, d_lo, d_mid, d_hi, quo_r};
      out_tuser_r <= {tick_r, show_local_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

/* sv/battery_monitor_display_top.sv */
// Top level of the battery monitor display block.
//
// Channel  Direction  Signals                                   Purpose
// in_      slave      in_tvalid/in_tready, in_tdata, in_tuser   raw sample, remote volts, tick
// out_     master     out_tvalid/out_tready, out_tdata, out_tuser  digits, voltages, alarm
// cfg_     slave      cfg_valid/cfg_ready, cfg_index, cfg_data  threshold registers
//
// An item passes through the one-bit-per-cycle divider forming the mean and then the
// bit-serial BCD converter; the next item is accepted only after its result is loaded.
// Reset (rst_n low, synchronous) empties the sample ring by clearing its fill flag
// and holds in_tready and cfg_ready low; no clearing pass is needed. The result sits
// in an output register, so a stalled out_tready only holds the block once the next
// result is finished.
`default_nettype none

module battery_monitor_display_top #(
  parameter int FILTER_DEPTH = bmd_pkg::FILTER_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input item channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // adc_sample[11:0], remote_volts[27:12], zero[31:28]
  input  wire logic [0:0]  in_tuser,   // tick_five_sec[0]
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // local_volts[8:0], digit_hi[12:9], digit_mid[16:13],
                                       // digit_lo[20:17], flicker_period[28:21],
                                       // alarm_on[29], zero[31:30]
  output logic [1:0]       out_tuser,  // shows_local[0], flicker_update[1]
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [bmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bmd_pkg::CFG_DATA_W-1:0] cfg_data
);

  bmd_pkg::cfg_t    cfg_r;
  bmd_pkg::cmd_t    cmd;
  bmd_pkg::status_t st;

  // Configuration registers; writes are taken whenever the block is out of reset.
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.product_kind <= 1'b0;
      cfg_r.fly_limit    <= bmd_pkg::FLY_LIMIT_RST;
      cfg_r.car_limit    <= bmd_pkg::CAR_LIMIT_RST;
      cfg_r.local_limit  <= bmd_pkg::LOCAL_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bmd_pkg::REG_PRODUCT_KIND: cfg_r.product_kind <= cfg_data[0];
        bmd_pkg::REG_FLY_LIMIT:    cfg_r.fly_limit    <= cfg_data;
        bmd_pkg::REG_CAR_LIMIT:    cfg_r.car_limit    <= cfg_data;
        bmd_pkg::REG_LOCAL_LIMIT:  cfg_r.local_limit  <= cfg_data[bmd_pkg::LOCAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller.
  bmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath.
  bmd_datapath #(
    .FILTER_DEPTH (FILTER_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .cfg        (cfg_r),
    .in_adc     (in_tdata[11:0]),
    .in_remote  (in_tdata[27:12]),
    .in_tick    (in_tuser[0]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Checks on the sequencing and on the result encoding.
`include "battery_monitor_display_top_assert.svh"

  `BMD_ASSERT_NEXT(a_one_item_at_a_time, in_tvalid && in_tready, !in_tready,
    "input accepted again before the current item finished")
  `BMD_ASSERT_NOW(a_digits_in_range,
    out_tvalid, (out_tdata[12:9] <= bmd_pkg::BLANK_DIGIT) &&
    (out_tdata[16:13] <= bmd_pkg::BLANK_DIGIT) &&
    (out_tdata[20:17] <= bmd_pkg::BLANK_DIGIT), "digit code out of range")
  `BMD_ASSERT_NOW(a_local_in_range, out_tvalid, out_tdata[8:0] <= 9'd449,
    "local voltage above full scale")
  `BMD_ASSERT_NOW(a_period_only_on_tick, out_tvalid && !out_tuser[1],
    out_tdata[28:21] == bmd_pkg::FLICK_OFF, "flicker period set without a tick")

endmodule

`default_nettype wire
